>>> sv/i2cb_pkg.sv
// ---------------------------------------------------------------------------
// i2cb_pkg
// Shared types and constants for the I2C register burst master.
// ---------------------------------------------------------------------------
package i2cb_pkg;

    localparam int MAX_BURST = 16;
    localparam int BUF_AW    = $clog2(MAX_BURST);
    localparam int IDX_W     = 5;

    localparam logic [15:0] ACK_TIMEOUT_RST = 16'h0FFF;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ADDR_NACK = 2'd1;
    localparam logic [1:0] ST_DATA_NACK = 2'd2;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_S0, PH_S1, PH_S2,
        PH_AW_LO, PH_AW_HI, PH_AW_ACK_LO, PH_AW_ACK_HI,
        PH_RG_LO, PH_RG_HI, PH_RG_ACK_LO, PH_RG_ACK_HI,
        PH_WD_LO, PH_WD_HI, PH_WD_ACK_LO, PH_WD_ACK_HI,
        PH_RS0, PH_RS1, PH_RS2,
        PH_AR_LO, PH_AR_HI, PH_AR_ACK_LO, PH_AR_ACK_HI,
        PH_RD_LO, PH_RD_HI, PH_RD_ACK_LO, PH_RD_ACK_HI,
        PH_SP0, PH_SP1, PH_SP2
    } t_phase;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic       rd_valid;
        logic [7:0] rd_byte;
        logic       rd_last;
    } t_res;

    typedef struct packed {
        logic              we;
        logic [BUF_AW-1:0] addr;
        logic [7:0]        data;
    } t_buf_wr;

endpackage

>>> sv/i2c_register_burst_master_top.sv
// ---------------------------------------------------------------------------
// i2c_register_burst_master_top
// I2C master running one register read or write burst at a time.
//
// Input channel (i_valid / o_stall): each transaction carries an op. A start
// op latches address, register, length and direction; a load op appends a
// byte to the write buffer unless full; a tick op samples SDA and advances
// the bus by at most one phase. Load and start are taken only while idle.
// Output channel (o_valid / i_stall): exactly one result per input
// transaction, in order, with line levels, busy, done/status and read data.
// Config channel (i_cfg_valid / o_cfg_ready): writes the ack timeout, always
// ready; write it only while the block is idle.
// Each accepted input's result is registered in the output register; one
// transaction per cycle sustained while o_stall is low. A waiting result
// under i_stall holds the output register and raises o_stall until taken;
// a result leaving frees it in the same cycle. Reset puts the bus idle with
// both lines released, drops the result valid and sets ack timeout to 4095.
// ---------------------------------------------------------------------------
module i2c_register_burst_master_top
    import i2cb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic        i_sda_in,
    input  logic [6:0]  i_dev_addr,
    input  logic [7:0]  i_reg_addr,
    input  logic [4:0]  i_length,
    input  logic        i_is_read,
    input  logic [7:0]  i_wr_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_scl,
    output logic        o_sda_out,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [1:0]  o_status,
    output logic        o_rd_valid,
    output logic [7:0]  o_rd_byte,
    output logic        o_rd_last
);

    logic              r_ovalid, n_ovalid;
    t_res              r_res;
    t_res              res;
    logic [15:0]       r_ack_timeout;
    logic              in_acc;
    t_buf_wr           buf_wr;
    logic [BUF_AW-1:0] buf_raddr;
    logic [7:0]        buf_rdata;

    assign o_stall     = r_ovalid && i_stall;
    assign in_acc      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    i2cb_wbuf #(
        .WIDTH (8),
        .DEPTH (MAX_BURST)
    ) u_wbuf (
        .i_clk   (i_clk),
        .i_we    (buf_wr.we),
        .i_waddr (buf_wr.addr),
        .i_wdata (buf_wr.data),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rdata)
    );

    i2cb_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (in_acc),
        .i_op          (i_op),
        .i_sda_in      (i_sda_in),
        .i_dev_addr    (i_dev_addr),
        .i_reg_addr    (i_reg_addr),
        .i_length      (i_length),
        .i_is_read     (i_is_read),
        .i_wr_byte     (i_wr_byte),
        .i_ack_timeout (r_ack_timeout),
        .i_buf_rdata   (buf_rdata),
        .o_buf_raddr   (buf_raddr),
        .o_buf_wr      (buf_wr),
        .o_res         (res)
    );

    always_comb begin
        n_ovalid = r_ovalid;
        if (in_acc) begin
            n_ovalid = 1'b1;
        end else if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid      <= 1'b0;
            r_ack_timeout <= ACK_TIMEOUT_RST;
        end else begin
            r_ovalid <= n_ovalid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_ack_timeout <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res <= res;
        end
    end

    assign o_valid    = r_ovalid;
    assign o_scl      = r_res.scl;
    assign o_sda_out  = r_res.sda_out;
    assign o_busy_res = r_res.busy_res;
    assign o_done_res = r_res.done_res;
    assign o_status   = r_res.status;
    assign o_rd_valid = r_res.rd_valid;
    assign o_rd_byte  = r_res.rd_byte;
    assign o_rd_last  = r_res.rd_last;

endmodule

>>> sv/i2cb_wbuf.sv
// ---------------------------------------------------------------------------
// i2cb_wbuf
// Generic RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module i2cb_wbuf #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/i2cb_seq.sv
// ---------------------------------------------------------------------------
// i2cb_seq
// Bus phase sequencer: advances one phase per accepted tick, holding while idle
// or waiting for an ack, and forms the result of each accepted transaction.
// ---------------------------------------------------------------------------
module i2cb_seq
    import i2cb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [1:0]        i_op,
    input  logic              i_sda_in,
    input  logic [6:0]        i_dev_addr,
    input  logic [7:0]        i_reg_addr,
    input  logic [4:0]        i_length,
    input  logic              i_is_read,
    input  logic [7:0]        i_wr_byte,
    input  logic [15:0]       i_ack_timeout,
    input  logic [7:0]        i_buf_rdata,
    output logic [BUF_AW-1:0] o_buf_raddr,
    output t_buf_wr           o_buf_wr,
    output t_res              o_res
);

    t_phase           r_phase, n_phase;
    logic [2:0]       r_bit_cnt, n_bit_cnt;
    logic [7:0]       r_shift, n_shift;
    logic [IDX_W-1:0] r_byte_idx, n_byte_idx;
    logic [IDX_W-1:0] r_load_idx, n_load_idx;
    logic [15:0]      r_ack_wait, n_ack_wait;
    logic [6:0]       r_dev, n_dev;
    logic [7:0]       r_reg, n_reg;
    logic [IDX_W-1:0] r_len, n_len;
    logic             r_read, n_read;
    logic [1:0]       r_line, n_line;
    logic [1:0]       r_end_st, n_end_st;

    logic             tick;
    logic             idle;
    logic             load_ok;
    logic [IDX_W:0]   idx_inc;
    logic             rd_last;
    logic [16:0]      wait_inc;
    logic             ack_end;
    logic             acked;
    logic             drv_scl;
    logic             drv_sda;

    assign tick     = i_en && (i_op == OP_TICK);
    assign idle     = (r_phase == PH_IDLE);
    assign load_ok  = i_en && (i_op == OP_LOAD) && idle
                      && (r_load_idx < IDX_W'(MAX_BURST));
    assign idx_inc  = {1'b0, r_byte_idx} + {{IDX_W{1'b0}}, 1'b1};
    assign rd_last  = idx_inc >= {1'b0, r_len};
    assign wait_inc = {1'b0, r_ack_wait} + 17'd1;
    assign acked    = !i_sda_in;
    assign ack_end  = acked || (wait_inc > {1'b0, i_ack_timeout});

    // next data byte address, stable for the whole byte so the read is ready
    assign o_buf_raddr = ((r_phase >= PH_WD_LO) && (r_phase <= PH_WD_ACK_HI))
                         ? idx_inc[BUF_AW-1:0] : '0;

    always_comb begin
        o_buf_wr.we   = load_ok;
        o_buf_wr.addr = r_load_idx[BUF_AW-1:0];
        o_buf_wr.data = i_wr_byte;
    end

    // line drive for this phase
    always_comb begin
        drv_scl = r_line[1];
        drv_sda = r_line[0];
        if (tick) begin
            case (r_phase)
                PH_IDLE: begin
                    drv_scl = 1'b1;
                    drv_sda = 1'b1;
                end
                PH_S0, PH_RS0: begin
                    drv_scl = 1'b0;
                    drv_sda = 1'b1;
                end
                PH_S1, PH_RS1: begin
                    drv_scl = 1'b1;
                    drv_sda = 1'b1;
                end
                PH_S2, PH_RS2: begin
                    drv_scl = 1'b1;
                    drv_sda = 1'b0;
                end
                PH_AW_LO, PH_RG_LO, PH_WD_LO, PH_AR_LO: begin
                    drv_scl = 1'b0;
                    drv_sda = r_shift[7];
                end
                PH_AW_HI, PH_RG_HI, PH_WD_HI, PH_AR_HI: begin
                    drv_scl = 1'b1;
                    drv_sda = r_shift[7];
                end
                PH_AW_ACK_LO, PH_RG_ACK_LO, PH_WD_ACK_LO, PH_AR_ACK_LO, PH_RD_LO: begin
                    drv_scl = 1'b0;
                    drv_sda = 1'b1;
                end
                PH_AW_ACK_HI, PH_RG_ACK_HI, PH_WD_ACK_HI, PH_AR_ACK_HI, PH_RD_HI: begin
                    drv_scl = 1'b1;
                    drv_sda = 1'b1;
                end
                PH_RD_ACK_LO: begin
                    drv_scl = 1'b0;
                    drv_sda = rd_last;
                end
                PH_RD_ACK_HI: begin
                    drv_scl = 1'b1;
                    drv_sda = rd_last;
                end
                PH_SP0: begin
                    drv_scl = 1'b0;
                    drv_sda = 1'b0;
                end
                PH_SP1: begin
                    drv_scl = 1'b1;
                    drv_sda = 1'b0;
                end
                PH_SP2: begin
                    drv_scl = 1'b1;
                    drv_sda = 1'b1;
                end
                default: begin
                    drv_scl = 1'b1;
                    drv_sda = 1'b1;
                end
            endcase
        end
    end

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_bit_cnt  = r_bit_cnt;
        n_shift    = r_shift;
        n_byte_idx = r_byte_idx;
        n_load_idx = r_load_idx;
        n_ack_wait = r_ack_wait;
        n_dev      = r_dev;
        n_reg      = r_reg;
        n_len      = r_len;
        n_read     = r_read;
        n_line     = r_line;
        n_end_st   = r_end_st;

        if (load_ok) begin
            n_load_idx = r_load_idx + IDX_W'(1);
        end

        if (i_en && (i_op == OP_START) && idle) begin
            n_dev      = i_dev_addr;
            n_reg      = i_reg_addr;
            n_len      = (i_length > IDX_W'(MAX_BURST)) ? IDX_W'(MAX_BURST) : i_length;
            n_read     = i_is_read;
            n_load_idx = '0;
            n_end_st   = ST_OK;
            n_phase    = PH_S0;
        end

        if (tick) begin
            n_line = {drv_scl, drv_sda};
            case (r_phase)
                PH_S0:  n_phase = PH_S1;
                PH_S1:  n_phase = PH_S2;
                PH_RS0: n_phase = PH_RS1;
                PH_RS1: n_phase = PH_RS2;
                PH_S2: begin
                    n_shift   = {r_dev, 1'b0};
                    n_bit_cnt = '0;
                    n_phase   = PH_AW_LO;
                end
                PH_RS2: begin
                    n_shift   = {r_dev, 1'b1};
                    n_bit_cnt = '0;
                    n_phase   = PH_AR_LO;
                end
                PH_AW_LO: n_phase = PH_AW_HI;
                PH_RG_LO: n_phase = PH_RG_HI;
                PH_WD_LO: n_phase = PH_WD_HI;
                PH_AR_LO: n_phase = PH_AR_HI;
                PH_AW_HI, PH_RG_HI, PH_WD_HI, PH_AR_HI: begin
                    n_shift = {r_shift[6:0], 1'b0};
                    if (r_bit_cnt == 3'd7) begin
                        n_bit_cnt  = '0;
                        n_ack_wait = '0;
                        n_phase    = t_phase'(r_phase + 5'd1);
                    end else begin
                        n_bit_cnt = r_bit_cnt + 3'd1;
                        n_phase   = t_phase'(r_phase - 5'd1);
                    end
                end
                PH_AW_ACK_LO: n_phase = PH_AW_ACK_HI;
                PH_RG_ACK_LO: n_phase = PH_RG_ACK_HI;
                PH_WD_ACK_LO: n_phase = PH_WD_ACK_HI;
                PH_AR_ACK_LO: n_phase = PH_AR_ACK_HI;
                PH_AW_ACK_HI, PH_RG_ACK_HI, PH_WD_ACK_HI, PH_AR_ACK_HI: begin
                    if (!ack_end) begin
                        n_ack_wait = wait_inc[15:0];
                    end else begin
                        case (r_phase)
                            PH_AW_ACK_HI: begin
                                if (acked) begin
                                    n_shift   = r_reg;
                                    n_bit_cnt = '0;
                                    n_phase   = PH_RG_LO;
                                end else begin
                                    n_end_st = ST_ADDR_NACK;
                                    n_phase  = PH_SP0;
                                end
                            end
                            PH_RG_ACK_HI: begin
                                if (r_read) begin
                                    n_phase = PH_RS0;
                                end else if (r_len == '0) begin
                                    n_end_st = ST_OK;
                                    n_phase  = PH_SP0;
                                end else begin
                                    n_byte_idx = '0;
                                    n_shift    = i_buf_rdata;
                                    n_bit_cnt  = '0;
                                    n_phase    = PH_WD_LO;
                                end
                            end
                            PH_WD_ACK_HI: begin
                                if (!acked) begin
                                    n_end_st = ST_DATA_NACK;
                                    n_phase  = PH_SP0;
                                end else begin
                                    n_byte_idx = idx_inc[IDX_W-1:0];
                                    if (rd_last) begin
                                        n_end_st = ST_OK;
                                        n_phase  = PH_SP0;
                                    end else begin
                                        n_shift   = i_buf_rdata;
                                        n_bit_cnt = '0;
                                        n_phase   = PH_WD_LO;
                                    end
                                end
                            end
                            default: begin
                                if (r_len == '0) begin
                                    n_end_st = ST_OK;
                                    n_phase  = PH_SP0;
                                end else begin
                                    n_byte_idx = '0;
                                    n_shift    = '0;
                                    n_bit_cnt  = '0;
                                    n_phase    = PH_RD_LO;
                                end
                            end
                        endcase
                    end
                end
                PH_RD_LO: n_phase = PH_RD_HI;
                PH_RD_HI: begin
                    n_shift = {r_shift[6:0], i_sda_in};
                    if (r_bit_cnt == 3'd7) begin
                        n_bit_cnt = '0;
                        n_phase   = PH_RD_ACK_LO;
                    end else begin
                        n_bit_cnt = r_bit_cnt + 3'd1;
                        n_phase   = PH_RD_LO;
                    end
                end
                PH_RD_ACK_LO: n_phase = PH_RD_ACK_HI;
                PH_RD_ACK_HI: begin
                    if (rd_last) begin
                        n_end_st = ST_OK;
                        n_phase  = PH_SP0;
                    end else begin
                        n_byte_idx = idx_inc[IDX_W-1:0];
                        n_shift    = '0;
                        n_bit_cnt  = '0;
                        n_phase    = PH_RD_LO;
                    end
                end
                PH_SP0: n_phase = PH_SP1;
                PH_SP1: n_phase = PH_SP2;
                PH_SP2: n_phase = PH_IDLE;
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    // result of this transaction
    always_comb begin
        o_res.scl      = drv_scl;
        o_res.sda_out  = drv_sda;
        o_res.busy_res = (n_phase != PH_IDLE);
        o_res.done_res = tick && (r_phase == PH_SP2);
        o_res.status   = (tick && (r_phase == PH_SP2)) ? r_end_st : ST_OK;
        o_res.rd_valid = tick && (r_phase == PH_RD_HI) && (r_bit_cnt == 3'd7);
        o_res.rd_byte  = o_res.rd_valid ? {r_shift[6:0], i_sda_in} : 8'd0;
        o_res.rd_last  = o_res.rd_valid && rd_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_bit_cnt  <= '0;
            r_shift    <= '0;
            r_byte_idx <= '0;
            r_load_idx <= '0;
            r_ack_wait <= '0;
            r_dev      <= '0;
            r_reg      <= '0;
            r_len      <= '0;
            r_read     <= 1'b0;
            r_line     <= 2'b11;
            r_end_st   <= ST_OK;
        end else begin
            r_phase    <= n_phase;
            r_bit_cnt  <= n_bit_cnt;
            r_shift    <= n_shift;
            r_byte_idx <= n_byte_idx;
            r_load_idx <= n_load_idx;
            r_ack_wait <= n_ack_wait;
            r_dev      <= n_dev;
            r_reg      <= n_reg;
            r_len      <= n_len;
            r_read     <= n_read;
            r_line     <= n_line;
            r_end_st   <= n_end_st;
        end
    end

endmodule
